### rtl/core/i2da_pkg.sv
// Shared types and constants for the integer to decimal ASCII unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package i2da_pkg;
	localparam int NUM_W       = 64;   // width of the binary number
	localparam int BCD_DIGITS  = 20;   // decimal digits a 64-bit value can need
	localparam int BITS_PER_STEP = 2;  // binary bits taken in per conversion cycle
	localparam int CONV_STEPS  = NUM_W / BITS_PER_STEP;
	localparam int STEP_CNT_W  = $clog2(CONV_STEPS);
	localparam int DIG_IDX_W   = $clog2(BCD_DIGITS);
	localparam int CHAR_W      = 6;

	localparam logic [CHAR_W-1:0] CODE_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CODE_NUL  = CHAR_W'(0);

	typedef logic [3:0] digit_t;

	// Control handed from the sequencer to the digit chain.
	typedef struct packed {
		logic load;   // take a new magnitude and clear all digits
		logic shift;  // one conversion step
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;
endpackage
`default_nettype wire

### rtl/core/i2da_bcd_cell.sv
// One decimal digit cell of the shift-and-add-3 converter.
// Depends on i2da_pkg for the digit type.
`default_nettype none
module i2da_bcd_cell
	import i2da_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   clr,
	input  wire logic   en,
	input  wire logic   in_hi,
	input  wire logic   in_lo,
	output      digit_t digit,
	output      logic   out_hi,
	output      logic   out_lo
);
	digit_t digit_q;
	digit_t d1;
	digit_t t1;
	digit_t d2;

	function automatic digit_t adjust(input digit_t d);
		adjust = (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
	endfunction

	// Two bits per cycle while en is high: the higher bit enters first, then the lower one.
	always_comb begin
		d1     = adjust(digit_q);
		out_hi = d1[3];
		t1     = {d1[2:0], in_hi};
		d2     = adjust(t1);
		out_lo = d2[3];
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			digit_q <= '0;
		end else if (en) begin
			digit_q <= {d2[2:0], in_lo};
		end
	end

	assign digit = digit_q;
endmodule
`default_nettype wire

### rtl/core/i2da_bcd_chain.sv
// Row of decimal digit cells fed from a binary shift register.
// Depends on i2da_pkg and i2da_bcd_cell.
`default_nettype none
module i2da_bcd_chain
	import i2da_pkg::*;
(
	input  wire logic             clk,
	input  wire chain_ctrl_t      ctrl,
	input  wire logic [NUM_W-1:0] magnitude,
	output      digit_t           digits [BCD_DIGITS]
);
	logic [NUM_W-1:0] bin_q;
	logic [BCD_DIGITS:0] hi_link;
	logic [BCD_DIGITS:0] lo_link;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= magnitude;
		end else if (ctrl.shift) begin
			bin_q <= {bin_q[NUM_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
		end
	end

	assign hi_link[0] = bin_q[NUM_W-1];
	assign lo_link[0] = bin_q[NUM_W-2];

	for (genvar k = 0; k < BCD_DIGITS; k++) begin : g_cell
		i2da_bcd_cell u_cell (
			.clk    (clk),
			.clr    (ctrl.load),
			.en     (ctrl.shift),
			.in_hi  (hi_link[k]),
			.in_lo  (lo_link[k]),
			.digit  (digits[k]),
			.out_hi (hi_link[k+1]),
			.out_lo (lo_link[k+1])
		);
	end
endmodule
`default_nettype wire

### rtl/core/integer_to_decimal_ascii_unit.sv
// Top level of the integer to decimal ASCII unit: sequencer and character output.
// Depends on i2da_pkg and i2da_bcd_chain.
//
// A word is taken when start is high and busy is low. The magnitude is converted
// by a row of twenty decimal digit cells that take in two binary bits per cycle;
// then one character leaves per cycle, digit_count digits (at least one, at most
// MAX_DIGITS) most significant first and a NUL when terminate is set, and busy is
// low again in the cycle the final character is shown. Every character is valid
// for one cycle only, marked by result_valid, and the receiver cannot stall it.
`default_nettype none
module integer_to_decimal_ascii_unit
	import i2da_pkg::*;
#(
	parameter int MAX_DIGITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire logic [NUM_W-1:0] number,
	input  wire logic             mode,
	input  wire logic [5:0]       digit_count,
	input  wire logic             terminate,
	output      logic             result_valid,
	output      logic [CHAR_W-1:0] char_code,
	output      logic             last_char
);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	state_t                state_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [CNT_W-1:0]      pos_q;
	logic                  term_q;
	logic                  nul_q;
	logic                  valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic             accept;
	logic [NUM_W-1:0] magnitude;
	logic [5:0]       count_sat;
	chain_ctrl_t      ctrl;
	digit_t           digits [BCD_DIGITS];
	digit_t           cur_digit;
	logic             pos_in_row;

	assign accept    = start && (state_q == ST_IDLE);
	assign magnitude = (mode && number[NUM_W-1]) ? (~number + NUM_W'(1)) : number;

	always_comb begin
		if (digit_count == 6'd0) begin
			count_sat = 6'd1;
		end else if (digit_count > 6'(MAX_DIGITS)) begin
			count_sat = 6'(MAX_DIGITS);
		end else begin
			count_sat = digit_count;
		end
	end

	assign ctrl = '{load: accept, shift: (state_q == ST_CONV)};

	i2da_bcd_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.magnitude (magnitude),
		.digits    (digits)
	);

	// Positions above the twentieth digit are always zero padding.
	assign pos_in_row = pos_q < CNT_W'(BCD_DIGITS);
	assign cur_digit  = pos_in_row ? digits[pos_q[DIG_IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			step_q  <= '0;
			nul_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						step_q  <= '0;
						nul_q   <= 1'b0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_CNT_W'(1);
					if (step_q == STEP_CNT_W'(CONV_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					valid_q <= 1'b1;
					if (nul_q) begin
						state_q <= ST_IDLE;
					end else if (pos_q == '0) begin
						if (term_q) begin
							nul_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= CNT_W'(count_sat - 6'd1);
			term_q <= terminate;
		end else if (state_q == ST_EMIT && !nul_q && pos_q != '0) begin
			pos_q <= pos_q - CNT_W'(1);
		end
		if (state_q == ST_EMIT) begin
			if (nul_q) begin
				char_q <= CODE_NUL;
				last_q <= 1'b1;
			end else begin
				char_q <= CODE_ZERO + CHAR_W'(cur_digit);
				last_q <= (pos_q == '0) && !term_q;
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign char_code    = char_q;
	assign last_char    = last_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_EMIT))
		else $error("character shown outside the emit phase");

	a_no_char_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_char) |=> !result_valid)
		else $error("character follows the final one of a word");

	a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && last_char))
		else $error("busy dropped without a final character");
endmodule
`default_nettype wire
